### rtl/core/pwfd_pkg.sv
// shared types and constants of the pulse width frame decoder
// no dependencies
package pwfd_pkg;
   localparam int unsigned TimeWidth  = 64;
   localparam int unsigned EventWidth = 32;
   localparam int unsigned UsWidth    = 24;
   localparam int unsigned ErrWidth   = 56;
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_TRIGGER_MIN = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TRIGGER_MAX = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_NIBBLE_MIN  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_NIBBLE_MAX  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_GUARD       = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_STOP        = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_ERROR_LIMIT = 3'd6;

   typedef struct packed {
      logic                  level;
      logic [TimeWidth-1:0]  edge_time;
      logic [TimeWidth-1:0]  sync_time;
      logic [EventWidth-1:0] event_number;
   } req_item_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  trigger_time;
      logic [TimeWidth-1:0]  trigger_sync_time;
      logic [EventWidth-1:0] frame_word;
      logic [ErrWidth-1:0]   error_sum;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SQUARE, ST_ACCUM, ST_DONE, ST_OUT
   } state_type;
endpackage

### rtl/core/pwfd_if.sv
// valid/ready channel interfaces for request and result items
// depends on pwfd_pkg
interface pwfd_req_if import pwfd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface pwfd_rsp_if import pwfd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

### rtl/core/pwfd_pulse_eval.sv
// per-pulse deviation square and nibble decode, two register stages
// depends on pwfd_pkg
module pwfd_pulse_eval import pwfd_pkg::*; #(
   parameter int unsigned NIBBLE_OFFSET = 500,
   parameter int unsigned NIBBLE_STEP   = 1000
) (
   input  logic                 clock,
   input  logic [TimeWidth-1:0] width,
   input  logic [UsWidth-1:0]   lo,
   input  logic [UsWidth-1:0]   hi,
   output logic [ErrWidth-1:0]  dev_sq,
   output logic [3:0]           nibble
);
   logic [TimeWidth-1:0] dev_in;
   logic [27:0]          dev_ff;
   logic                 dev_big_in, dev_big_ff;
   logic [3:0]           nib_in, nib_ff;
   logic [ErrWidth-1:0]  sq_ff;
   logic [TimeWidth-1:0] rem;

   always_comb begin
      dev_in = '0;
      if (width < {40'd0, lo}) dev_in = {40'd0, lo} - width;
      else if (width > {40'd0, hi}) dev_in = width - {40'd0, hi};
      dev_big_in = |dev_in[TimeWidth-1:28];
      // quotient by compare against multiples of the step, clamped to 15
      nib_in = 4'd0;
      if (width >= TimeWidth'(NIBBLE_OFFSET)) begin
         rem = width - TimeWidth'(NIBBLE_OFFSET);
         for (int k = 1; k < 16; k++) begin
            if (rem >= TimeWidth'(k) * TimeWidth'(NIBBLE_STEP)) nib_in = 4'(k);
         end
      end else begin
         rem = '0;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff     <= dev_in[27:0];
      dev_big_ff <= dev_big_in;
      nib_ff     <= nib_in;
      sq_ff      <= dev_big_ff ? '1 : {28'd0, dev_ff} * {28'd0, dev_ff};
      nibble     <= nib_ff;
   end
   assign dev_sq = sq_ff;
endmodule

### rtl/core/pulse_width_frame_decoder_unit.sv
// top level of the pulse width frame decoder: edge ring memory and window walk
// depends on pwfd_pkg, pwfd_if, pwfd_pulse_eval
//
//  channel | dir | contents
//  req     | in  | level, edge_time, sync_time, event_number
//  rsp     | out | trigger_time, trigger_sync_time, frame_word, error_sum
//  csr     | in  | write enable, index 0..6, 56-bit data
//
// an item that completes a window holds the input while the walk runs: a memory
// read step and a pulse setup step per held edge, a settle step, a wait until
// the two-stage square unit has drained and a step to load the result
// other items are taken on consecutive cycles; a window failing its checks or
// reaching the error limit gives no result; a result waiting in the output
// register holds the walk in its last state; reset clears fill count, write
// pointer, walk state and output valid, resets the csr; memory is not cleared
module pulse_width_frame_decoder_unit import pwfd_pkg::*; #(
   parameter int unsigned WINDOW_PULSES = 17,
   parameter int unsigned NIBBLE_OFFSET = 500,
   parameter int unsigned NIBBLE_STEP   = 1000
) (
   input  logic                   clock,
   input  logic                   reset,
   pwfd_req_if.sink               req,
   pwfd_rsp_if.source             rsp,
   input  logic                   csr_write,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ErrWidth-1:0]    csr_data
);
   localparam int unsigned Depth  = WINDOW_PULSES + 1;
   localparam int unsigned PtrW   = $clog2(Depth);
   localparam int unsigned CntW   = $clog2(Depth + 1);
   localparam int unsigned EntryW = 1 + 2 * TimeWidth + EventWidth;

   // configuration registers
   logic [UsWidth-1:0]  trig_min_ff, trig_max_ff, nib_min_ff, nib_max_ff, guard_ff, stop_ff;
   logic [ErrWidth-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_min_ff <= UsWidth'(10000);
         trig_max_ff <= UsWidth'(700000);
         nib_min_ff  <= UsWidth'(1000);
         nib_max_ff  <= UsWidth'(16000);
         guard_ff    <= UsWidth'(4000);
         stop_ff     <= UsWidth'(10000);
         limit_ff    <= ErrWidth'(64'd17000000000);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TRIGGER_MIN: trig_min_ff <= csr_data[UsWidth-1:0];
            CSR_TRIGGER_MAX: trig_max_ff <= csr_data[UsWidth-1:0];
            CSR_NIBBLE_MIN:  nib_min_ff  <= csr_data[UsWidth-1:0];
            CSR_NIBBLE_MAX:  nib_max_ff  <= csr_data[UsWidth-1:0];
            CSR_GUARD:       guard_ff    <= csr_data[UsWidth-1:0];
            CSR_STOP:        stop_ff     <= csr_data[UsWidth-1:0];
            CSR_ERROR_LIMIT: limit_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // edge ring: circular memory, the write pointer marks the oldest edge once full
   logic [EntryW-1:0] ring_mem [Depth];
   logic [EntryW-1:0] rd_data_ff;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_addr;
   logic [CntW-1:0]   held_ff, held_in;
   logic              mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[wr_ptr_ff] <= req.item;
      rd_data_ff <= ring_mem[rd_addr];
   end

   // walk state
   state_type            state_ff, state_in;
   logic [PtrW-1:0]      idx_ff, idx_in;        // edge index relative to oldest
   logic [PtrW-1:0]      pul_ff, pul_in;        // pulses accumulated so far
   logic                 fail_ff, fail_in;
   req_item_type         prev_ff, prev_in, first_ff, first_in, cur;
   logic [ErrWidth-1:0]  err_ff, err_in;
   logic [EventWidth-1:0] frame_ff, frame_in;
   rsp_item_type         out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   logic [TimeWidth-1:0] width_ff, width_in;
   logic [UsWidth-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic                 isnib_ff, isnib_in, isnib_d1_ff, isnib_d2_ff;
   logic [ErrWidth-1:0]  dev_sq;
   logic [3:0]           nibble;
   logic [ErrWidth:0]    sum;
   // pulse results in flight: width registered at setup step, eval pipe two deep
   logic [2:0]           acc_valid_ff;

   pwfd_pulse_eval #(.NIBBLE_OFFSET(NIBBLE_OFFSET), .NIBBLE_STEP(NIBBLE_STEP)) u_eval (
      .clock(clock), .width(width_ff), .lo(lo_ff), .hi(hi_ff),
      .dev_sq(dev_sq), .nibble(nibble)
   );

   function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] a,
                                                input logic [PtrW-1:0] b);
      logic [PtrW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PtrW+1)'(Depth)) s = s - (PtrW+1)'(Depth);
      return s[PtrW-1:0];
   endfunction

   // input is free whenever the walk is idle; the output register parts the two sides
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.item  = out_ff;
   assign cur       = req_item_type'(rd_data_ff);
   assign sum       = {1'b0, err_ff} + {1'b0, dev_sq};

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; pul_in = pul_ff; fail_in = fail_ff;
      prev_in = prev_ff; first_in = first_ff; err_in = err_ff; frame_in = frame_ff;
      out_in = out_ff; out_valid_in = out_valid_ff; wr_ptr_in = wr_ptr_ff;
      held_in = held_ff; width_in = width_ff; lo_in = lo_ff; hi_in = hi_ff;
      isnib_in = isnib_ff; mem_we = 1'b0;
      // oldest edge after this write is the write slot once the ring is full
      rd_addr = wrap_add(wr_ptr_ff, idx_ff);
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      // fold in a finished pulse, error sum saturating
      if (acc_valid_ff[2]) begin
         err_in = sum[ErrWidth] ? '1 : sum[ErrWidth-1:0];
         if (isnib_d2_ff) frame_in = {frame_ff[EventWidth-5:0], nibble};
         pul_in = pul_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               mem_we = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
               if (held_ff == CntW'(Depth - 1) || held_ff == CntW'(Depth)) begin
                  held_in = CntW'(Depth);
                  idx_in = '0; pul_in = '0; fail_in = 1'b0; err_in = '0; frame_in = '0;
                  state_in = ST_READ;
               end else begin
                  held_in = held_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            // wr_ptr already advanced, so it points to the oldest edge
            rd_addr = wrap_add(wr_ptr_ff, idx_ff);
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (idx_ff == '0) begin
               first_in = cur;
            end else begin
               width_in = cur.edge_time - prev_ff.edge_time;
               isnib_in = 1'b0;
               if (idx_ff == PtrW'(1)) begin
                  lo_in = trig_min_ff; hi_in = trig_max_ff;
                  if (!prev_ff.level) fail_in = 1'b1;
               end else if (idx_ff == PtrW'(WINDOW_PULSES)) begin
                  lo_in = stop_ff; hi_in = stop_ff;
                  if (!prev_ff.level) fail_in = 1'b1;
               end else if (idx_ff[0] == 1'b0) begin
                  lo_in = nib_min_ff; hi_in = nib_max_ff; isnib_in = 1'b1;
                  if (prev_ff.level) fail_in = 1'b1;
               end else begin
                  lo_in = guard_ff; hi_in = guard_ff;
                  if (!prev_ff.level) fail_in = 1'b1;
               end
               if (prev_ff.event_number + 1'b1 != cur.event_number) fail_in = 1'b1;
            end
            prev_in = cur;
            if (idx_ff == PtrW'(WINDOW_PULSES)) begin
               state_in = ST_ACCUM;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_ACCUM: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait until the eval pipe has delivered the last pulse
            if (pul_ff == PtrW'(WINDOW_PULSES)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (fail_ff || err_ff >= limit_ff) begin
               state_in = ST_IDLE;
            end else if (!out_valid_ff || rsp.ready) begin
               out_in.trigger_time      = first_ff.edge_time;
               out_in.trigger_sync_time = first_ff.sync_time;
               out_in.frame_word        = frame_ff;
               out_in.error_sum         = err_ff;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_valid_ff <= 1'b0; held_ff <= '0; wr_ptr_ff <= '0;
         acc_valid_ff <= '0;
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in; held_ff <= held_in;
         wr_ptr_ff <= wr_ptr_in;
         acc_valid_ff <= {acc_valid_ff[1:0], (state_ff == ST_SQUARE) && (idx_ff != '0)};
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; pul_ff <= pul_in; fail_ff <= fail_in; prev_ff <= prev_in;
      first_ff <= first_in; out_ff <= out_in; width_ff <= width_in;
      lo_ff <= lo_in; hi_ff <= hi_in; isnib_ff <= isnib_in;
      isnib_d1_ff <= isnib_ff; isnib_d2_ff <= isnib_d1_ff;
      err_ff <= err_in; frame_ff <= frame_in;
   end
endmodule

### rtl/core/pwfd_checker.sv
// port-level checks of the pulse width frame decoder
// depends on pwfd_pkg and the top level ports
module pwfd_checker import pwfd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item)) else $error("rsp dropped");
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid})) else $error("handshake unknown");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid)) else $error("result too early");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready)) else $error("result without walk");
endmodule

bind pulse_width_frame_decoder_unit pwfd_checker u_pwfd_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.item)
);
